@@ sv/dtq_pkg.sv @@
`default_nettype none

package dtq_pkg;

    // Fixed port widths
    localparam int OP_W   = 2;
    localparam int ID_W   = 4;
    localparam int TICK_W = 48;
    localparam int ST_W   = 3;
    localparam int IDX_W  = 5;
    localparam int NEXT_W = 49;

    typedef enum logic [OP_W-1:0] {
        OP_SCHED   = 2'd0,
        OP_UNSCHED = 2'd1,
        OP_EXEC    = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_LATE     = 3'd1,
        ST_PENDING  = 3'd2,
        ST_IDLE_TSK = 3'd3,
        ST_BACKWARD = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPLY,
        S_SUM,
        S_FSCAN,
        S_FEMIT,
        S_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;        // latch the request
        logic apply;       // check and update state for the request
        logic scan_start;  // begin a pass over the entries
        logic fire_mode;   // pass looks for the earliest entry
        logic drop;        // remove the earliest entry found
        logic show_fire;   // current result reports a fired task
    } dtq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;
        logic firing;
        logic any_due;
        logic last_fire;
    } dtq_stat_t;

endpackage

`default_nettype wire

@@ sv/dtq_ram.sv @@
`default_nettype none

module dtq_ram #(
    parameter int W = 48,
    parameter int D = 16
) (
    input  wire logic                            clk,
    input  wire logic                            we,
    input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
    input  wire logic [W-1:0]                    wdata,
    input  wire logic                            re,
    input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
    output logic      [W-1:0]                    rdata
);

    logic [W-1:0] mem [D];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/dtq_ctrl.sv @@
`default_nettype none

module dtq_ctrl
    import dtq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_ready,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    input  wire dtq_stat_t stat,
    output dtq_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        rsp_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                cmd.apply      = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = S_SUM;
            end
            S_SUM:
            begin
                if (stat.scan_done)
                begin
                    if (stat.firing && stat.any_due)
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.fire_mode  = 1'b1;
                        state_next     = S_FSCAN;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_FSCAN:
            begin
                if (stat.scan_done)
                begin
                    cmd.drop   = 1'b1;
                    state_next = S_FEMIT;
                end
            end
            S_FEMIT:
            begin
                rsp_valid     = 1'b1;
                cmd.show_fire = 1'b1;
                if (rsp_ready)
                begin
                    if (stat.last_fire)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.fire_mode  = 1'b1;
                        state_next     = S_FSCAN;
                    end
                end
            end
            S_EMIT:
            begin
                rsp_valid = 1'b1;
                if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/dtq_dp.sv @@
`default_nettype none

module dtq_dp
    import dtq_pkg::*;
#(
    parameter int NIDS = 16,
    parameter int TW   = 48
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [OP_W-1:0]          req_op,
    input  wire logic [ID_W-1:0]          req_id,
    input  wire logic [TICK_W-1:0]        req_ticks,
    input  wire dtq_cmd_t                 cmd,
    output dtq_stat_t                     stat,
    output logic [ST_W-1:0]               rsp_status,
    output logic                          rsp_fired_valid,
    output logic [ID_W-1:0]               rsp_fired_task,
    output logic [TICK_W-1:0]             rsp_fired_deadline,
    output logic [IDX_W-1:0]              rsp_fire_index,
    output logic                          rsp_last,
    output logic signed [NEXT_W-1:0]      rsp_next_deadline,
    output logic [IDX_W-1:0]              rsp_pending_count
);

    localparam int IW = (NIDS > 1) ? $clog2(NIDS) : 1;
    localparam int CW = $clog2(NIDS + 1);

    // Latched request
    op_t            op_reg;
    logic [ID_W-1:0] id_reg;
    logic [TW-1:0]  t_reg;

    // Queue state
    logic           lt_have_reg;
    logic [TW-1:0]  lt_reg;
    logic [NIDS-1:0] pending_reg;
    logic [IW-1:0]  rank_reg [NIDS];
    logic [CW-1:0]  cnt_reg;
    status_t        status_reg;
    logic           firing_reg;

    // Scan sequencing
    logic           active_reg;
    logic [IW-1:0]  idx_reg;
    logic           mode_reg;
    logic           rd_v_reg;
    logic [IW-1:0]  rd_idx_reg;
    logic           fin_reg;
    logic [TW-1:0]  rd_dl;

    // Summary results
    logic           have_reg;
    logic [TW-1:0]  min_reg;
    logic [CW-1:0]  n_due_reg;
    logic [CW-1:0]  out_cnt_reg;

    // Earliest entry found
    logic           bhave_reg;
    logic [IW-1:0]  best_id_reg;
    logic [TW-1:0]  best_dl_reg;
    logic [IW-1:0]  best_rank_reg;
    logic [CW-1:0]  fire_idx_reg;

    // Request checks
    logic           id_ok;
    logic [IW-1:0]  id_idx;
    logic           pend_id;
    logic           late;
    logic           backward;
    status_t        chk_status;
    logic           do_sched;
    logic           do_unsched;
    logic           do_exec;
    logic           drop_en;
    logic [IW-1:0]  drop_idx;
    logic [IW-1:0]  drop_rank;
    logic           rd_pend;
    logic [IW-1:0]  rd_rank;
    logic           rd_due;

    always_comb
    begin
        id_idx   = id_reg[IW-1:0];
        id_ok    = int'(id_reg) < NIDS;
        pend_id  = id_ok && pending_reg[id_idx];
        late     = lt_have_reg && (t_reg <= lt_reg);
        backward = lt_have_reg && (t_reg < lt_reg);
        chk_status = ST_OK;
        case (op_reg)
            OP_SCHED:
            begin
                if (late)
                begin
                    chk_status = ST_LATE;
                end
                else if (!id_ok || pend_id)
                begin
                    chk_status = ST_PENDING;
                end
            end
            OP_UNSCHED:
            begin
                if (!pend_id)
                begin
                    chk_status = ST_IDLE_TSK;
                end
            end
            OP_EXEC:
            begin
                if (backward)
                begin
                    chk_status = ST_BACKWARD;
                end
            end
            default:
            begin
                chk_status = ST_OK;
            end
        endcase
        do_sched   = cmd.apply && (op_reg == OP_SCHED) && (chk_status == ST_OK);
        do_unsched = cmd.apply && (op_reg == OP_UNSCHED) && (chk_status == ST_OK);
        do_exec    = cmd.apply && (op_reg == OP_EXEC) && (chk_status == ST_OK);

        // One removal path for unschedule and for firing
        drop_en   = do_unsched || cmd.drop;
        drop_idx  = cmd.drop ? best_id_reg : id_idx;
        drop_rank = cmd.drop ? best_rank_reg : rank_reg[id_idx];
    end

    // Request latch
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= op_t'(req_op);
            id_reg <= req_id;
            t_reg  <= req_ticks[TW-1:0];
        end
    end

    // Deadline store
    dtq_ram #(
        .W (TW),
        .D (NIDS)
    ) u_dl_ram (
        .clk   (clk),
        .we    (do_sched),
        .waddr (id_idx),
        .wdata (t_reg),
        .re    (active_reg),
        .raddr (idx_reg),
        .rdata (rd_dl)
    );

    // Pending flags, count, last time, status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            cnt_reg     <= '0;
            lt_have_reg <= 1'b0;
            firing_reg  <= 1'b0;
            status_reg  <= ST_OK;
        end
        else
        begin
            if (cmd.apply)
            begin
                status_reg <= chk_status;
                firing_reg <= do_exec;
            end
            if (do_sched)
            begin
                pending_reg[id_idx] <= 1'b1;
                cnt_reg             <= cnt_reg + 1'b1;
            end
            else if (drop_en)
            begin
                pending_reg[drop_idx] <= 1'b0;
                cnt_reg               <= cnt_reg - 1'b1;
            end
            if (do_exec)
            begin
                lt_have_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_exec)
        begin
            lt_reg <= t_reg;
        end
    end

    // Ranks: new task goes last, later ones close the gap on removal
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NIDS; j++)
        begin
            if (do_sched && (id_idx == IW'(j)))
            begin
                rank_reg[j] <= cnt_reg[IW-1:0];
            end
            else if (drop_en && pending_reg[j] && (rank_reg[j] > drop_rank))
            begin
                rank_reg[j] <= rank_reg[j] - 1'b1;
            end
        end
    end

    // Scan sequencer: one entry per cycle through the registered read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
            mode_reg   <= 1'b0;
            rd_v_reg   <= 1'b0;
            fin_reg    <= 1'b0;
        end
        else
        begin
            rd_v_reg <= active_reg && !cmd.scan_start;
            fin_reg  <= rd_v_reg && !cmd.scan_start && (rd_idx_reg == IW'(NIDS - 1));
            if (cmd.scan_start)
            begin
                active_reg <= 1'b1;
                idx_reg    <= '0;
                mode_reg   <= cmd.fire_mode;
            end
            else if (active_reg)
            begin
                if (idx_reg == IW'(NIDS - 1))
                begin
                    active_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= idx_reg;
    end

    always_comb
    begin
        rd_pend = pending_reg[rd_idx_reg];
        rd_rank = rank_reg[rd_idx_reg];
        rd_due  = firing_reg && (rd_dl <= t_reg);
    end

    // Scan accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg     <= 1'b0;
            n_due_reg    <= '0;
            bhave_reg    <= 1'b0;
            fire_idx_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                fire_idx_reg <= '0;
            end
            else if (cmd.drop)
            begin
                fire_idx_reg <= fire_idx_reg + 1'b1;
            end
            if (cmd.scan_start)
            begin
                if (cmd.fire_mode)
                begin
                    bhave_reg <= 1'b0;
                end
                else
                begin
                    have_reg  <= 1'b0;
                    n_due_reg <= '0;
                end
            end
            else if (rd_v_reg && rd_pend)
            begin
                if (mode_reg)
                begin
                    if (!bhave_reg || (rd_dl < best_dl_reg) ||
                        ((rd_dl == best_dl_reg) && (rd_rank < best_rank_reg)))
                    begin
                        bhave_reg <= 1'b1;
                    end
                end
                else if (rd_due)
                begin
                    n_due_reg <= n_due_reg + 1'b1;
                end
                else if (!have_reg || (rd_dl < min_reg))
                begin
                    have_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!cmd.scan_start && rd_v_reg && rd_pend)
        begin
            if (mode_reg)
            begin
                if (!bhave_reg || (rd_dl < best_dl_reg) ||
                    ((rd_dl == best_dl_reg) && (rd_rank < best_rank_reg)))
                begin
                    best_id_reg   <= rd_idx_reg;
                    best_dl_reg   <= rd_dl;
                    best_rank_reg <= rd_rank;
                end
            end
            else if (!rd_due && (!have_reg || (rd_dl < min_reg)))
            begin
                min_reg <= rd_dl;
            end
        end
        // Final pending count once the summary pass is through
        if (fin_reg && !mode_reg)
        begin
            out_cnt_reg <= cnt_reg - n_due_reg;
        end
    end

    // Status to controller
    always_comb
    begin
        stat.scan_done = fin_reg;
        stat.firing    = firing_reg;
        stat.any_due   = (n_due_reg != '0);
        stat.last_fire = (fire_idx_reg == n_due_reg);
    end

    // Result fields
    always_comb
    begin
        rsp_status         = status_reg;
        rsp_fired_valid    = cmd.show_fire;
        rsp_fired_task     = '0;
        rsp_fired_deadline = '0;
        rsp_fire_index     = '0;
        rsp_last           = 1'b1;
        if (cmd.show_fire)
        begin
            rsp_fired_task[IW-1:0]     = best_id_reg;
            rsp_fired_deadline[TW-1:0] = best_dl_reg;
            rsp_fire_index[CW-1:0]     = fire_idx_reg;
            rsp_last                   = (fire_idx_reg == n_due_reg);
        end
        rsp_next_deadline = '1;
        if (have_reg)
        begin
            rsp_next_deadline         = '0;
            rsp_next_deadline[TW-1:0] = min_reg;
        end
        rsp_pending_count           = '0;
        rsp_pending_count[CW-1:0]   = out_cnt_reg;
    end

    // Count tracks the pending flags
    a_cnt_match: assert property (@(posedge clk) disable iff (!rst_n)
        int'(cnt_reg) == $countones(pending_reg))
        else $error("pending count differs from pending flags");

    // A fired task was found and is due
    a_drop_due: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drop |-> (bhave_reg && (best_dl_reg <= t_reg) && pending_reg[best_id_reg]))
        else $error("firing a task that is not due");

    // Never fire more tasks than counted due
    a_fire_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drop |-> (fire_idx_reg < n_due_reg))
        else $error("fired more tasks than were due");

endmodule

`default_nettype wire

@@ sv/deadline_timer_queue.sv @@
// Deadline timer queue.
// Request channel (req_valid/req_ready): op, task_id, ticks. Schedule (op 0)
// makes task_id pending at deadline ticks, unschedule (op 1) drops it,
// execute (op 2) records ticks as current time and fires every due task,
// earliest deadline first, FIFO order among equal deadlines.
// Result channel (rsp_valid/rsp_ready): one result per request, or one per
// fired task for an execute that fires, with last on the final one. Each
// result carries the earliest pending deadline (-1 when empty) and the
// pending count as they stand once the request is done.
// One request is handled at a time; req_ready is high only when idle.
// Each pass over the deadline store reads one entry per cycle through the
// store's registered read port and covers N entries, N being TASKS capped
// at 16. Once taken, a request is applied and a summary pass runs before
// its first result; an execute that fires runs a further pass before the
// result of each fired task.
// A stalled receiver holds the result; no further work is done until taken.
// Reset empties the queue and clears the last execute time; the store
// itself is not cleared, so requests are taken right after reset.
`default_nettype none

module deadline_timer_queue
    import dtq_pkg::*;
#(
    parameter int TASKS     = 16,
    parameter int TIME_BITS = 48
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    req_valid,
    output logic                         req_ready,
    input  wire logic [OP_W-1:0]         op,
    input  wire logic [ID_W-1:0]         task_id,
    input  wire logic [TICK_W-1:0]       ticks,
    output logic                         rsp_valid,
    input  wire logic                    rsp_ready,
    output logic [ST_W-1:0]              status,
    output logic                         fired_valid,
    output logic [ID_W-1:0]              fired_task,
    output logic [TICK_W-1:0]            fired_deadline,
    output logic [IDX_W-1:0]             fire_index,
    output logic                         last,
    output logic signed [NEXT_W-1:0]     next_deadline,
    output logic [IDX_W-1:0]             pending_count
);

    // Only ids below TASKS (at most 16) exist, and at most TIME_BITS of the port's tick bits are kept
    localparam int NIDS = (TASKS < 16) ? TASKS : 16;
    localparam int TW   = (TIME_BITS < TICK_W) ? TIME_BITS : TICK_W;

    dtq_cmd_t  cmd;
    dtq_stat_t stat;

    dtq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dtq_dp #(
        .NIDS (NIDS),
        .TW   (TW)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .req_op             (op),
        .req_id             (task_id),
        .req_ticks          (ticks),
        .cmd                (cmd),
        .stat               (stat),
        .rsp_status         (status),
        .rsp_fired_valid    (fired_valid),
        .rsp_fired_task     (fired_task),
        .rsp_fired_deadline (fired_deadline),
        .rsp_fire_index     (fire_index),
        .rsp_last           (last),
        .rsp_next_deadline  (next_deadline),
        .rsp_pending_count  (pending_count)
    );

endmodule

`default_nettype wire

@@ sim/dtq_checker.sv @@
`default_nettype none

// Watches both channels of the deadline timer queue, predicts the results
// of every accepted request and compares them in order.
module dtq_checker
    import dtq_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     req_valid,
    input  wire logic                     req_ready,
    input  wire logic [OP_W-1:0]          op,
    input  wire logic [ID_W-1:0]          task_id,
    input  wire logic [TICK_W-1:0]        ticks,
    input  wire logic                     rsp_valid,
    input  wire logic                     rsp_ready,
    input  wire logic [ST_W-1:0]          status,
    input  wire logic                     fired_valid,
    input  wire logic [ID_W-1:0]          fired_task,
    input  wire logic [TICK_W-1:0]        fired_deadline,
    input  wire logic [IDX_W-1:0]         fire_index,
    input  wire logic                     last,
    input  wire logic signed [NEXT_W-1:0] next_deadline,
    input  wire logic [IDX_W-1:0]         pending_count,
    output int                            fail_count,
    output int                            outstanding
);

    localparam int SLOTS = 16;

    typedef struct {
        logic [ST_W-1:0]          status;
        logic                     fired_valid;
        logic [ID_W-1:0]          fired_task;
        logic [TICK_W-1:0]        fired_deadline;
        logic [IDX_W-1:0]         fire_index;
        logic                     last;
        logic signed [NEXT_W-1:0] next_deadline;
        logic [IDX_W-1:0]         pending_count;
    } timer_result_t;

    // Expected results, oldest first
    timer_result_t awaited_results[$];

    // Shadow copy of the queue
    logic [TICK_W-1:0]        due_at [SLOTS];
    logic                     armed [SLOTS];
    logic [7:0]               rank [SLOTS];
    logic [7:0]               armed_count;
    logic signed [NEXT_W-1:0] exec_time;

    // Earliest pending task; FIFO rank breaks ties
    function automatic int earliest_task();
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (armed[i] && (best < 0 || due_at[i] < due_at[best] ||
                (due_at[i] == due_at[best] && rank[i] < rank[best])))
                best = i;
        end
        return best;
    endfunction

    // Remove a task and close the gap in the rank order
    function automatic void retire_task(int id);
        armed[id] = 1'b0;
        for (int j = 0; j < SLOTS; j++) begin
            if (armed[j] && rank[j] > rank[id])
                rank[j] = rank[j] - 8'd1;
        end
        if (armed_count > 0)
            armed_count = armed_count - 8'd1;
    endfunction

    // Queue one expected result; summary fields reflect the current state
    function automatic void queue_result(status_t st, logic fv, logic [ID_W-1:0] tk,
                                         logic [TICK_W-1:0] dl, logic [IDX_W-1:0] idx,
                                         logic lst);
        timer_result_t r;
        int e;
        e = earliest_task();
        r.status         = st;
        r.fired_valid    = fv;
        r.fired_task     = tk;
        r.fired_deadline = dl;
        r.fire_index     = idx;
        r.last           = lst;
        r.next_deadline  = (e < 0) ? '1 : {1'b0, due_at[e]};
        r.pending_count  = armed_count[IDX_W-1:0];
        awaited_results.push_back(r);
    endfunction

    // Apply one request to the shadow queue and queue its results
    function automatic void timer_queue_step(logic [OP_W-1:0] code, logic [ID_W-1:0] id,
                                             logic [TICK_W-1:0] t);
        logic signed [NEXT_W-1:0] stamp;
        int                       fired_id [SLOTS];
        logic [TICK_W-1:0]        fired_at [SLOTS];
        int                       n;
        int                       e;
        stamp = {1'b0, t};
        n = 0;
        case (op_t'(code))
            OP_SCHED: begin
                // late deadline wins over the pending test
                if (stamp <= exec_time)
                    queue_result(ST_LATE, 1'b0, '0, '0, '0, 1'b1);
                else if (armed[id])
                    queue_result(ST_PENDING, 1'b0, '0, '0, '0, 1'b1);
                else begin
                    due_at[id]  = t;
                    armed[id]   = 1'b1;
                    rank[id]    = armed_count;
                    armed_count = armed_count + 8'd1;
                    queue_result(ST_OK, 1'b0, '0, '0, '0, 1'b1);
                end
            end
            OP_UNSCHED: begin
                if (!armed[id])
                    queue_result(ST_IDLE_TSK, 1'b0, '0, '0, '0, 1'b1);
                else begin
                    retire_task(id);
                    queue_result(ST_OK, 1'b0, '0, '0, '0, 1'b1);
                end
            end
            OP_EXEC: begin
                if (stamp < exec_time)
                    queue_result(ST_BACKWARD, 1'b0, '0, '0, '0, 1'b1);
                else begin
                    exec_time = stamp;
                    // fire everything due, earliest first
                    while (n < SLOTS) begin
                        e = earliest_task();
                        if (e < 0 || due_at[e] > t)
                            break;
                        fired_id[n] = e;
                        fired_at[n] = due_at[e];
                        retire_task(e);
                        n++;
                    end
                    if (n == 0)
                        queue_result(ST_OK, 1'b0, '0, '0, '0, 1'b1);
                    for (int k = 0; k < n; k++)
                        queue_result(ST_OK, 1'b1, fired_id[k][ID_W-1:0], fired_at[k],
                                     IDX_W'(k + 1), k == n - 1);
                end
            end
            default: queue_result(ST_OK, 1'b0, '0, '0, '0, 1'b1);
        endcase
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 'h%0h, got 'h%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Results are matched before the request of the same edge is predicted
    always @(posedge clk or negedge rst_n) begin
        timer_result_t want;
        if (!rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                due_at[i] = '0;
                armed[i]  = 1'b0;
                rank[i]   = '0;
            end
            armed_count = '0;
            exec_time   = '1;
            awaited_results.delete();
            outstanding <= 0;
        end
        else begin
            if (rsp_valid && rsp_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("unexpected result: task %0d, status %0d", fired_task, status);
                    fail_count++;
                end
                else begin
                    want = awaited_results.pop_front();
                    check_field("status", 64'(want.status), 64'(status));
                    check_field("fired_valid", 64'(want.fired_valid), 64'(fired_valid));
                    check_field("fired_task", 64'(want.fired_task), 64'(fired_task));
                    check_field("fired_deadline", 64'(want.fired_deadline),
                                64'(fired_deadline));
                    check_field("fire_index", 64'(want.fire_index), 64'(fire_index));
                    check_field("last", 64'(want.last), 64'(last));
                    check_field("next_deadline", 64'(want.next_deadline),
                                64'(next_deadline));
                    check_field("pending_count", 64'(want.pending_count),
                                64'(pending_count));
                end
            end
            if (req_valid && req_ready)
                timer_queue_step(op, task_id, ticks);
            outstanding <= awaited_results.size();
        end
    end

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`default_nettype none

module tb
    import dtq_pkg::*;
();

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 40;
    localparam int PHASE_ITEMS = 108;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Request side
    logic               req_valid = 1'b0;
    wire logic          req_ready;
    logic [OP_W-1:0]    op        = '0;
    logic [ID_W-1:0]    task_id   = '0;
    logic [TICK_W-1:0]  ticks     = '0;

    // Result side
    wire logic                     rsp_valid;
    logic                          rsp_ready = 1'b1;
    wire logic [ST_W-1:0]          status;
    wire logic                     fired_valid;
    wire logic [ID_W-1:0]          fired_task;
    wire logic [TICK_W-1:0]        fired_deadline;
    wire logic [IDX_W-1:0]         fire_index;
    wire logic                     last;
    wire logic signed [NEXT_W-1:0] next_deadline;
    wire logic [IDX_W-1:0]         pending_count;

    int fail_count;
    int outstanding;

    // Idling control and the time the queue has last executed at
    bit                tx_calm;
    bit                rx_calm;
    logic [TICK_W-1:0] clock_now;
    bit                clock_known;

    int unsigned cycles;
    bit          took;
    bit          drawn;
    int          rx_hold;

    deadline_timer_queue dut (.*);

    dtq_checker chk (.*);

    always #2 clk = ~clk;

    // Run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: a random stall for each result once it shows up
    always @(posedge clk) took <= rsp_valid && rsp_ready;

    always @(negedge clk) begin
        if (took)
            drawn = 1'b0;
        if (rsp_valid && !drawn) begin
            rx_hold = rx_calm ? 0 : $urandom_range(0, 6);
            drawn   = 1'b1;
        end
        if (rx_hold > 0) begin
            rsp_ready <= 1'b0;
            rx_hold--;
        end
        else
            rsp_ready <= 1'b1;
    end

    // Send one request after a random gap; valid stays up across back-to-back requests
    task automatic send_request(op_t code, logic [ID_W-1:0] id, logic [TICK_W-1:0] t);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 6);
        @(negedge clk);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        op        <= code;
        task_id   <= id;
        ticks     <= t;
        do @(posedge clk); while (!req_ready);
        if (code == OP_EXEC && (!clock_known || t >= clock_now)) begin
            clock_now   = t;
            clock_known = 1'b1;
        end
    endtask

    // Hold off until every expected result is in
    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Mostly well-formed traffic around the current time, some late and backward noise
    task automatic random_request();
        int                pick;
        int                r;
        logic [ID_W-1:0]   id;
        logic [TICK_W-1:0] t;
        pick = $urandom_range(0, 99);
        r    = $urandom_range(0, 99);
        id   = ID_W'($urandom_range(0, 15));
        if (pick < 45) begin
            if (r < 85)
                t = clock_now + 1 + $urandom_range(0, 40);
            else if (r < 90)
                t = clock_now;
            else if (r < 95)
                t = clock_now - $urandom_range(1, 60);
            else
                t = TICK_W'({$urandom, $urandom});
            send_request(OP_SCHED, id, t);
        end
        else if (pick < 62)
            send_request(OP_UNSCHED, id, TICK_W'({$urandom, $urandom}));
        else if (pick < 96) begin
            if (r < 88)
                t = clock_now + $urandom_range(0, 25);
            else
                t = clock_now - $urandom_range(1, 20);
            send_request(OP_EXEC, id, t);
        end
        else
            send_request(OP_NOP, id, TICK_W'({$urandom, $urandom}));
    endtask

    initial begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: errors, extremes and a full queue firing at once
        send_request(OP_SCHED, 4'd0, 48'd0);
        send_request(OP_SCHED, 4'd0, 48'd5);
        send_request(OP_UNSCHED, 4'd3, 48'd0);
        send_request(OP_SCHED, 4'd15, '1);
        send_request(OP_EXEC, 4'd0, 48'd0);
        send_request(OP_UNSCHED, 4'd15, '1);
        send_request(OP_NOP, 4'd9, 48'd123);
        for (int i = 0; i < 16; i++)
            send_request(OP_SCHED, ID_W'(15 - i), TICK_W'(10 + i % 3));
        // late deadline on a pending task
        send_request(OP_SCHED, 4'd0, 48'd0);
        send_request(OP_EXEC, 4'd0, 48'd100);
        send_request(OP_EXEC, 4'd0, 48'd99);
        send_request(OP_EXEC, 4'd0, 48'd100);
        drain();

        // Random phases with different idling
        for (int p = 0; p < 4; p++) begin
            tx_calm = (p == 1) || (p == 2);
            rx_calm = (p == 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_request();
            drain();
        end

        // Flush whatever is still pending
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        send_request(OP_EXEC, 4'd0, '1);
        drain();

        if (fail_count == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
